[src/utf8e_pkg.sv]
// shared types, constants and the utf-8 encode function
`default_nettype none
package utf8e_pkg;

  localparam logic [20:0] REPL_CHAR    = 21'h00FFFD;
  localparam logic [20:0] HIGH_SURR_LO = 21'h00D800;
  localparam logic [20:0] LOW_SURR_LO  = 21'h00DC00;
  localparam logic [20:0] SURR_END     = 21'h00E000;
  localparam logic [20:0] CODE_MAX     = 21'h10FFFF;
  localparam logic [10:0] SUPP_HI_BASE = 11'h040;
  localparam logic [2:0]  FLUSH_LEN    = 3'd3;
  localparam int          QUEUE_DEPTH  = 2;

  localparam logic [2:0][7:0] REPL_BYTES = {8'hBD, 8'hBF, 8'hEF};

  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
  } utf8_seq_t;

  typedef struct packed {
    logic      flush;
    utf8_seq_t seq;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic utf8_seq_t utf8_encode(input logic [20:0] cp_in);
    logic [20:0] cp;
    utf8_seq_t   s;
    cp = (cp_in > CODE_MAX) ? REPL_CHAR : cp_in;
    s.bytes = '0;
    priority if (cp < 21'h000080) begin
      s.nbytes   = 3'd1;
      s.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h000800) begin
      s.nbytes   = 3'd2;
      s.bytes[0] = {3'b110, cp[10:6]};
      s.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h010000) begin
      s.nbytes   = 3'd3;
      s.bytes[0] = {4'b1110, cp[15:12]};
      s.bytes[1] = {2'b10, cp[11:6]};
      s.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      s.nbytes   = 3'd4;
      s.bytes[0] = {5'b11110, cp[20:18]};
      s.bytes[1] = {2'b10, cp[17:12]};
      s.bytes[2] = {2'b10, cp[11:6]};
      s.bytes[3] = {2'b10, cp[5:0]};
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[src/utf8e_if.sv]
// valid/ready channel interfaces for code values and utf-8 bytes
`default_nettype none
interface utf8e_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [20:0] code_value;
  modport source (output valid, action, code_value, input ready);
  modport sink (input valid, action, code_value, output ready);
endinterface

interface utf8e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface
`default_nettype wire

[src/utf8e_front.sv]
// front end: surrogate pairing and utf-8 encoding into jobs
`default_nettype none
module utf8e_front
  import utf8e_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [20:0] in_code_value,
  input  wire q_stat_t     q_stat,
  output logic             push,
  output job_t             push_job
);

  logic       pend_r, pend_nxt;
  logic [9:0] hi_r, hi_nxt;
  logic       accept, is_low, is_high, do_enc;
  logic [20:0] enc_cp, pair_cp;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign is_low   = (in_code_value >= LOW_SURR_LO) && (in_code_value < SURR_END);
  assign is_high  = (in_code_value >= HIGH_SURR_LO) && (in_code_value < LOW_SURR_LO);
  assign pair_cp  = {11'({1'b0, hi_r} + SUPP_HI_BASE), in_code_value[9:0]};

  always_comb begin
    pend_nxt       = pend_r;
    hi_nxt         = hi_r;
    push_job.flush = 1'b0;
    do_enc         = 1'b0;
    enc_cp         = in_code_value;
    if (in_action) begin
      push_job.flush = pend_r;
      pend_nxt       = 1'b0;
    end else if (pend_r && is_low) begin
      do_enc   = 1'b1;
      enc_cp   = pair_cp;
      pend_nxt = 1'b0;
    end else begin
      push_job.flush = pend_r;
      pend_nxt       = 1'b0;
      if (is_high) begin
        pend_nxt = 1'b1;
        hi_nxt   = in_code_value[9:0];
      end else if (is_low) begin
        do_enc = 1'b1;
        enc_cp = REPL_CHAR;
      end else begin
        do_enc = 1'b1;
      end
    end
    push_job.seq = utf8_encode(enc_cp);
    if (!do_enc) begin
      push_job.seq.nbytes = 3'd0;
    end
  end

  assign push = accept && (push_job.flush || do_enc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (accept) begin
      pend_r <= pend_nxt;
    end
    if (accept) begin
      hi_r <= hi_nxt;
    end
  end

endmodule
`default_nettype wire

[src/utf8e_queue.sv]
// small job queue between front and back
`default_nettype none
module utf8e_queue
  import utf8e_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output q_stat_t   q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign head_job     = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

[src/utf8e_back.sv]
// back end: walks a job out one byte per cycle, when out_ready allows, into the output register
`default_nettype none
module utf8e_back
  import utf8e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire job_t       head_job,
  input  wire q_stat_t    q_stat,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic [2:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load, is_last;
  logic [2:0] total, off;
  logic [7:0] sel_byte;

  assign load    = !q_stat.empty && (!valid_r || out_ready);
  assign total   = head_job.flush ? 3'(head_job.seq.nbytes + FLUSH_LEN)
                                  : head_job.seq.nbytes;
  assign is_last = (idx_r == total - 3'd1);
  assign pop     = load && is_last;
  assign off     = head_job.flush ? idx_r - FLUSH_LEN : idx_r;

  always_comb begin
    if (head_job.flush && idx_r < FLUSH_LEN) begin
      sel_byte = REPL_BYTES[idx_r[1:0]];
    end else begin
      sel_byte = head_job.seq.bytes[off[1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else if (load) begin
      idx_r   <= is_last ? '0 : idx_r + 3'd1;
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
    if (load) begin
      byte_r <= sel_byte;
      last_r <= is_last;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

[src/utf16_surrogate_to_utf8_encoder.sv]
// top level: utf-16 surrogate combiner and utf-8 encoder
`default_nettype none
// Takes code values or flush events on in_ch and gives utf-8 bytes on out_ch,
// one byte per transaction, with last_byte set on the final byte an item causes.
// A high surrogate is held until the next item; paired with a low surrogate it
// becomes one supplementary code point, otherwise it is replaced by U+FFFD, as
// are lone low surrogates and values above U+10FFFF. Items that cause no bytes
// (a held high surrogate, a flush with nothing held) produce no transaction.
// The front end accepts an item per cycle whenever the job queue has room; the
// single output byte register drains one byte per cycle while out_ch.ready
// allows. An item yields up to 7 bytes (1 to 4 for a plain code point).
module utf16_surrogate_to_utf8_encoder
  import utf8e_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input wire logic    clk,
  input wire logic    rst_n,
  utf8e_in_if.sink    in_ch,
  utf8e_out_if.source out_ch
);

  logic    q_push, q_pop;
  job_t    push_job, head_job;
  q_stat_t q_stat;

  utf8e_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_action     (in_ch.action),
    .in_code_value (in_ch.code_value),
    .q_stat        (q_stat),
    .push          (q_push),
    .push_job      (push_job)
  );

  utf8e_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  utf8e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last_byte)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty) else $error("job queue underflow");

  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (push_job.flush || push_job.seq.nbytes != 3'd0))
    else $error("job without bytes pushed");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_ch.valid && out_ch.last_byte))
    else $error("job end not marked on output");

endmodule
`default_nettype wire

[dv/utf16_surrogate_to_utf8_encoder_test.sv]
// testbench for the utf-16 surrogate to utf-8 encoder: directed and random code values
module utf16_surrogate_to_utf8_encoder_test;
  import utf8e_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_ITEMS = 95;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_byte_t;

  typedef struct packed {
    logic        act;
    logic [20:0] cv;
    logic        drain;
    logic        calm;
  } code_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  utf8e_in_if  in_ch ();
  utf8e_out_if out_ch ();

  utf16_surrogate_to_utf8_encoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  code_item_t  code_q[$];
  utf8_byte_t  utf8_q[$];
  logic [15:0] held_high;
  logic        calm = 1'b0;
  bit          pause_next = 1'b0;
  bit          calm_mode = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          items_queued = 0;
  int          items_done = 0;
  int          flushes_done = 0;
  int          bytes_seen = 0;
  int          errors = 0;
  int          cycles = 0;

  task automatic report(input string msg);
    $display("mismatch at byte %0d: %s", bytes_seen, msg);
    errors++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    utf8_byte_t e;
    e.data = b;
    e.last = 1'b0;
    utf8_q.push_back(e);
  endtask

  task automatic push_utf8(input logic [20:0] cp_in);
    logic [20:0] cp;
    cp = (cp_in > CODE_MAX) ? REPL_CHAR : cp_in;
    if (cp < 21'h000080) begin
      push_byte({1'b0, cp[6:0]});
    end else if (cp < 21'h000800) begin
      push_byte({3'b110, cp[10:6]});
      push_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h010000) begin
      push_byte({4'b1110, cp[15:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end else begin
      push_byte({5'b11110, cp[20:18]});
      push_byte({2'b10, cp[17:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic drop_held();
    if (held_high != 16'h0000) begin
      push_utf8(REPL_CHAR);
      held_high = 16'h0000;
    end
  endtask

  task automatic transcode_item(input logic act, input logic [20:0] cv);
    int          before_n;
    logic        is_low;
    logic [20:0] hv;
    utf8_byte_t  tail;
    before_n = utf8_q.size();
    is_low = (cv >= LOW_SURR_LO) && (cv < SURR_END);
    hv = {5'b0, held_high};
    if (act) begin
      drop_held();
    end else if (held_high != 16'h0000 && is_low) begin
      push_utf8(21'h010000 + ((hv - HIGH_SURR_LO) << 10) + (cv - LOW_SURR_LO));
      held_high = 16'h0000;
    end else begin
      drop_held();
      if (cv >= HIGH_SURR_LO && cv < LOW_SURR_LO) held_high = cv[15:0];
      else if (is_low) push_utf8(REPL_CHAR);
      else push_utf8(cv);
    end
    if (utf8_q.size() > before_n) begin
      tail = utf8_q.pop_back();
      tail.last = 1'b1;
      utf8_q.push_back(tail);
    end
  endtask

  task automatic queue_item(input logic act, input logic [20:0] cv);
    code_item_t it;
    it.act = act;
    it.cv = cv;
    it.drain = pause_next;
    it.calm = calm_mode;
    code_q.push_back(it);
    pause_next = 1'b0;
    items_queued++;
  endtask

  function automatic logic [20:0] rand_plain();
    logic [20:0] v;
    case ($urandom_range(0, 3))
      0: v = 21'($urandom_range(0, 21'h00007F));
      1: v = 21'($urandom_range(21'h000080, 21'h0007FF));
      2: begin
        v = 21'($urandom_range(21'h000800, 21'h00F7FF));
        if (v >= HIGH_SURR_LO) v = v + 21'h000800;
      end
      default: v = 21'($urandom_range(21'h010000, CODE_MAX));
    endcase
    return v;
  endfunction

  function automatic logic [20:0] rand_high();
    return 21'($urandom_range(HIGH_SURR_LO, LOW_SURR_LO - 1));
  endfunction

  function automatic logic [20:0] rand_low();
    return 21'($urandom_range(LOW_SURR_LO, SURR_END - 1));
  endfunction

  always @(posedge clk) begin : drive
    code_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        transcode_item(in_ch.action, in_ch.code_value);
        items_done++;
        if (in_ch.action) flushes_done++;
        if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 6);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (code_q.size() > 0 && !(code_q[0].drain && utf8_q.size() != 0)) begin
          nxt = code_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.action <= nxt.act;
          in_ch.code_value <= nxt.cv;
          calm <= nxt.calm;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    utf8_byte_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (utf8_q.size() == 0) begin
          report($sformatf("unexpected byte %02h last %0b", out_ch.out_byte, out_ch.last_byte));
        end else begin
          want = utf8_q.pop_front();
          if (out_ch.out_byte !== want.data)
            report($sformatf("byte %02h, want %02h", out_ch.out_byte, want.data));
          if (out_ch.last_byte !== want.last)
            report($sformatf("last mark %0b, want %0b", out_ch.last_byte, want.last));
        end
        bytes_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : timeout
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : run
    int          directed_n;
    logic [20:0] v;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.code_value = '0;
    out_ch.ready = 1'b0;
    held_high = 16'h0000;

    // boundaries of each encoded length and of the field
    queue_item(1'b0, 21'h000000);
    queue_item(1'b0, 21'h00007F);
    queue_item(1'b0, 21'h000080);
    queue_item(1'b0, 21'h0007FF);
    queue_item(1'b0, 21'h000800);
    queue_item(1'b0, 21'h00D7FF);
    queue_item(1'b0, 21'h00E000);
    queue_item(1'b0, 21'h00FFFF);
    queue_item(1'b0, 21'h010000);
    queue_item(1'b0, CODE_MAX);
    queue_item(1'b0, 21'h110000);
    queue_item(1'b0, 21'h1FFFFF);
    // flush with nothing held
    queue_item(1'b1, 21'h1FFFFF);
    // pairs at both ends of the surrogate ranges
    queue_item(1'b0, HIGH_SURR_LO);
    queue_item(1'b0, LOW_SURR_LO);
    queue_item(1'b0, LOW_SURR_LO - 1);
    queue_item(1'b0, SURR_END - 1);
    // held surrogate dropped by flush, by a second high, by plain values
    queue_item(1'b0, 21'h00DA12);
    queue_item(1'b1, 21'h000000);
    queue_item(1'b0, 21'h00D801);
    queue_item(1'b0, 21'h00DB00);
    queue_item(1'b0, 21'h000041);
    queue_item(1'b0, 21'h00D9AA);
    queue_item(1'b0, 21'h010000);
    // lone low surrogate, then held high followed by an out-of-range value
    queue_item(1'b0, 21'h00DEAD);
    queue_item(1'b0, 21'h00DBFF);
    queue_item(1'b0, 21'h1FFFFF);
    directed_n = items_queued;

    pause_next = 1'b1;
    while (items_queued - directed_n < RANDOM_ITEMS) begin
      if (items_queued - directed_n >= 50 && items_queued - directed_n < 52) pause_next = 1'b1;
      if (items_queued - directed_n >= RANDOM_ITEMS - 20) calm_mode = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: queue_item(1'b0, rand_plain());
        7, 8, 9, 10, 11, 12: begin
          queue_item(1'b0, rand_high());
          queue_item(1'b0, rand_low());
        end
        13, 14: begin
          queue_item(1'b0, rand_high());
          if ($urandom_range(0, 1)) queue_item(1'b0, rand_plain());
          else queue_item(1'b0, rand_high());
        end
        15: queue_item(1'b0, rand_low());
        16, 17: queue_item(1'b1, 21'($urandom_range(0, 21'h1FFFFF)));
        default: begin
          v = 21'($urandom_range(0, 21'h1FFFFF));
          queue_item(1'b0, v);
        end
      endcase
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (items_done != items_queued) @(posedge clk);
    while (utf8_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d code items, %0d of them flushes, and %0d utf-8 bytes",
             items_done, flushes_done, bytes_seen);
    $display("stimulus had pairs, lone and dropped surrogates and out-of-range values");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/utf8e_pkg.sv
src/utf8e_if.sv
src/utf8e_front.sv
src/utf8e_queue.sv
src/utf8e_back.sv
src/utf16_surrogate_to_utf8_encoder.sv
dv/utf16_surrogate_to_utf8_encoder_test.sv
